>>> design/hsv_pkg.sv
package hsv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = FRAC_BITS + 1;
  localparam int CH_W      = 8;
  localparam int H6_W      = IN_W + 3;
  localparam int PROD_W    = 2 * IN_W;
  localparam int SCALE_W   = IN_W + CH_W;

  localparam logic [IN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t                sector;
    logic [FRAC_BITS-1:0]   frac;
    logic [IN_W-1:0]        sat;
    logic [IN_W-1:0]        val;
  } prep_t;

  typedef struct packed {
    sector_t                sector;
    logic [IN_W-1:0]        p;
    logic [IN_W-1:0]        sq;
    logic [IN_W-1:0]        st;
    logic [IN_W-1:0]        val;
  } mid_t;

  typedef struct packed {
    sector_t                sector;
    logic [IN_W-1:0]        p;
    logic [IN_W-1:0]        q;
    logic [IN_W-1:0]        t;
    logic [IN_W-1:0]        val;
  } lvl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  function automatic logic [IN_W-1:0] mul_frac(input logic [IN_W-1:0] a,
                                               input logic [IN_W-1:0] b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b);
    return prod[FRAC_BITS +: IN_W];
  endfunction

  function automatic logic [CH_W-1:0] scale255(input logic [IN_W-1:0] level);
    logic [SCALE_W-1:0] prod;
    prod = {level, {CH_W{1'b0}}} - SCALE_W'(level);
    return prod[FRAC_BITS +: CH_W];
  endfunction

endpackage

>>> design/hsv_if.sv
interface hsv_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsv_pkg::IN_W-1:0]   hue;
  logic [hsv_pkg::IN_W-1:0]   saturation;
  logic [hsv_pkg::IN_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface rgb_out_if;
  logic                       valid;
  logic                       ready;
  logic [hsv_pkg::CH_W-1:0]   red;
  logic [hsv_pkg::CH_W-1:0]   green;
  logic [hsv_pkg::CH_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> design/hsv_prep.sv
module hsv_prep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hsv_pkg::IN_W-1:0]  hue,
  input  logic [hsv_pkg::IN_W-1:0]  saturation,
  input  logic [hsv_pkg::IN_W-1:0]  brightness,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsv_pkg::prep_t            out_data
);

  logic [hsv_pkg::IN_W-1:0] hue_w;
  logic [hsv_pkg::H6_W-1:0] h6;
  logic [hsv_pkg::H6_W-hsv_pkg::FRAC_BITS-1:0] sec_raw;
  hsv_pkg::prep_t           data_next;

  always_comb begin
    hue_w   = (hue == hsv_pkg::ONE) ? '0 : hue;
    h6      = (hsv_pkg::H6_W'(hue_w) << 2) + (hsv_pkg::H6_W'(hue_w) << 1);
    sec_raw = h6[hsv_pkg::H6_W-1:hsv_pkg::FRAC_BITS];
    if (sec_raw > 4'(hsv_pkg::SEC_MAG_RED)) begin
      data_next.sector = hsv_pkg::SEC_MAG_RED;
    end else begin
      data_next.sector = hsv_pkg::sector_t'(sec_raw[2:0]);
    end
    data_next.frac = h6[hsv_pkg::FRAC_BITS-1:0];
    data_next.sat  = (saturation > hsv_pkg::ONE) ? hsv_pkg::ONE : saturation;
    data_next.val  = (brightness > hsv_pkg::ONE) ? hsv_pkg::ONE : brightness;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

>>> design/hsv_level.sv
module hsv_level (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hsv_pkg::prep_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hsv_pkg::lvl_t   out_data
);

  logic           mid_valid;
  logic           mid_ready;
  hsv_pkg::mid_t  mid;
  hsv_pkg::mid_t  mid_next;
  hsv_pkg::lvl_t  lvl_next;
  logic [hsv_pkg::IN_W-1:0] frac_w;

  always_comb begin
    frac_w          = {1'b0, in_data.frac};
    mid_next.sector = in_data.sector;
    mid_next.val    = in_data.val;
    mid_next.p      = hsv_pkg::mul_frac(in_data.val, hsv_pkg::ONE - in_data.sat);
    mid_next.sq     = hsv_pkg::mul_frac(in_data.sat, frac_w);
    mid_next.st     = hsv_pkg::mul_frac(in_data.sat, hsv_pkg::ONE - frac_w);
  end

  always_comb begin
    lvl_next.sector = mid.sector;
    lvl_next.val    = mid.val;
    lvl_next.p      = mid.p;
    lvl_next.q      = hsv_pkg::mul_frac(mid.val, hsv_pkg::ONE - mid.sq);
    lvl_next.t      = hsv_pkg::mul_frac(mid.val, hsv_pkg::ONE - mid.st);
  end

  assign mid_ready = !out_valid || out_ready;
  assign in_ready  = !mid_valid || mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mid_valid <= in_valid;
      end
      if (mid_ready) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mid <= mid_next;
    end
    if (mid_valid && mid_ready) begin
      out_data <= lvl_next;
    end
  end

endmodule

>>> design/hsv_route.sv
module hsv_route (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hsv_pkg::lvl_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hsv_pkg::rgb_t   out_data
);

  logic [hsv_pkg::IN_W-1:0] r_lvl;
  logic [hsv_pkg::IN_W-1:0] g_lvl;
  logic [hsv_pkg::IN_W-1:0] b_lvl;
  hsv_pkg::rgb_t            rgb_next;

  always_comb begin
    unique case (in_data.sector)
      hsv_pkg::SEC_RED_YEL: begin
        r_lvl = in_data.val; g_lvl = in_data.t;   b_lvl = in_data.p;
      end
      hsv_pkg::SEC_YEL_GRN: begin
        r_lvl = in_data.q;   g_lvl = in_data.val; b_lvl = in_data.p;
      end
      hsv_pkg::SEC_GRN_CYN: begin
        r_lvl = in_data.p;   g_lvl = in_data.val; b_lvl = in_data.t;
      end
      hsv_pkg::SEC_CYN_BLU: begin
        r_lvl = in_data.p;   g_lvl = in_data.q;   b_lvl = in_data.val;
      end
      hsv_pkg::SEC_BLU_MAG: begin
        r_lvl = in_data.t;   g_lvl = in_data.p;   b_lvl = in_data.val;
      end
      default: begin
        r_lvl = in_data.val; g_lvl = in_data.p;   b_lvl = in_data.q;
      end
    endcase
    rgb_next.red   = hsv_pkg::scale255(r_lvl);
    rgb_next.green = hsv_pkg::scale255(g_lvl);
    rgb_next.blue  = hsv_pkg::scale255(b_lvl);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= rgb_next;
    end
  end

endmodule

>>> design/hsv_to_rgb_unit.sv
// HSV to RGB color converter, one pixel per beat.
//
// Channels: hsv (sink) carries hue, saturation and brightness as unsigned
// fractions of 2^16 (17 bits, so one is representable); rgb (source) carries
// 8-bit red, green and blue. A beat moves on a clock edge with valid and ready
// both high.
//
// Pipeline: four register stages (clamp and hue times six; p, S*f, S*(1-f);
// q and t; sector routing and scale by 255). An input beat passes through
// them in that order before it shows on rgb. Throughput is one pixel per
// cycle while rgb.ready stays high; the two multiply stages set the clock.
//
// Each stage holds its own valid bit and takes a new beat when it is empty or
// its successor takes its beat, so empty stages fill while rgb is stalled and
// nothing is dropped or repeated. Up to four pixels wait inside during a
// stall; hsv.ready falls only when all stages are full and rgb.ready is low.
//
// Reset (rst, synchronous, active high) empties all stages; rgb.valid is low
// in the cycle after reset.
module hsv_to_rgb_unit (
  input  logic      clk,
  input  logic      rst,
  hsv_in_if.sink    hsv,
  rgb_out_if.source rgb
);

  logic            prep_valid;
  logic            prep_ready;
  hsv_pkg::prep_t  prep_data;
  logic            lvl_valid;
  logic            lvl_ready;
  hsv_pkg::lvl_t   lvl_data;
  hsv_pkg::rgb_t   rgb_data;

  hsv_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hsv.valid),
    .in_ready   (hsv.ready),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .out_valid  (prep_valid),
    .out_ready  (prep_ready),
    .out_data   (prep_data)
  );

  hsv_level u_level (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_data  (lvl_data)
  );

  hsv_route u_route (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lvl_valid),
    .in_ready  (lvl_ready),
    .in_data   (lvl_data),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_data  (rgb_data)
  );

  assign rgb.red   = rgb_data.red;
  assign rgb.green = rgb_data.green;
  assign rgb.blue  = rgb_data.blue;

endmodule

>>> design/hsv_chk.sv
module hsv_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hsv_pkg::CH_W-1:0]  red,
  input logic [hsv_pkg::CH_W-1:0]  green,
  input logic [hsv_pkg::CH_W-1:0]  blue
);

  logic [2:0] inflight;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_beat) - 3'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("rgb valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("rgb payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> inflight != 3'd0)
    else $error("rgb beat with no pixel in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd4)
    else $error("more pixels in flight than pipeline stages");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("rgb valid after reset");

endmodule

bind hsv_to_rgb_unit hsv_chk u_hsv_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsv.valid),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red       (rgb.red),
  .green     (rgb.green),
  .blue      (rgb.blue)
);

>>> tb/sv/hsv_rgb_checker.sv
module hsv_rgb_checker (
  input  logic clk,
  input  logic rst,
  hsv_in_if    hsv,
  rgb_out_if   rgb,
  output int   fail_count,
  output int   pending
);
  import hsv_pkg::*;

  rgb_t pixel_q[$];

  function automatic logic [CH_W-1:0] to_channel(input logic [63:0] level);
    logic [63:0] scaled;
    scaled = (level * 64'd255) >> FRAC_BITS;
    return scaled[CH_W-1:0];
  endfunction

  function automatic rgb_t convert_pixel(input logic [IN_W-1:0] hue_in,
                                         input logic [IN_W-1:0] sat_in,
                                         input logic [IN_W-1:0] bri_in);
    logic [63:0] one_w, hue, sat, bri, h6, sec_num, f, p, q, t, sq, st;
    sector_t sec;
    rgb_t px;
    one_w = 64'(ONE);
    hue = 64'(hue_in);
    sat = 64'(sat_in);
    bri = 64'(bri_in);
    if (sat > one_w) sat = one_w;
    if (bri > one_w) bri = one_w;
    if (hue == one_w) hue = 0;
    h6 = hue * 64'd6;
    sec_num = h6 >> FRAC_BITS;
    if (sec_num > 64'd5) sec = SEC_MAG_RED;
    else sec = sector_t'(sec_num[2:0]);
    f = h6 & (one_w - 64'd1);
    p = (bri * (one_w - sat)) >> FRAC_BITS;
    sq = (sat * f) >> FRAC_BITS;
    q = (bri * (one_w - sq)) >> FRAC_BITS;
    st = (sat * (one_w - f)) >> FRAC_BITS;
    t = (bri * (one_w - st)) >> FRAC_BITS;
    case (sec)
      SEC_RED_YEL: begin
        px.red = to_channel(bri); px.green = to_channel(t); px.blue = to_channel(p);
      end
      SEC_YEL_GRN: begin
        px.red = to_channel(q); px.green = to_channel(bri); px.blue = to_channel(p);
      end
      SEC_GRN_CYN: begin
        px.red = to_channel(p); px.green = to_channel(bri); px.blue = to_channel(t);
      end
      SEC_CYN_BLU: begin
        px.red = to_channel(p); px.green = to_channel(q); px.blue = to_channel(bri);
      end
      SEC_BLU_MAG: begin
        px.red = to_channel(t); px.green = to_channel(p); px.blue = to_channel(bri);
      end
      default: begin
        px.red = to_channel(bri); px.green = to_channel(p); px.blue = to_channel(q);
      end
    endcase
    return px;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst) begin
      if (hsv.valid && hsv.ready)
        pixel_q.push_back(convert_pixel(hsv.hue, hsv.saturation, hsv.brightness));
      if (rgb.valid && rgb.ready) begin
        if (pixel_q.size() == 0) begin
          $error("rgb beat with no pixel pending: %0d %0d %0d",
                 rgb.red, rgb.green, rgb.blue);
          fail_count = fail_count + 1;
        end else begin
          want = pixel_q.pop_front();
          if (rgb.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, rgb.red);
            fail_count = fail_count + 1;
          end
          if (rgb.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, rgb.green);
            fail_count = fail_count + 1;
          end
          if (rgb.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, rgb.blue);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = pixel_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  import hsv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PIXELS = 930;
  localparam logic [IN_W-1:0] TOP_IN = {IN_W{1'b1}};

  logic clk;
  logic rst;
  logic steady;
  int   fail_count;
  int   pending;
  int   cycles;
  int   stall_left;

  hsv_in_if  hsv ();
  rgb_out_if rgb ();

  hsv_to_rgb_unit uut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv),
    .rgb (rgb)
  );

  hsv_rgb_checker chk (
    .clk        (clk),
    .rst        (rst),
    .hsv        (hsv),
    .rgb        (rgb),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    else if (pick < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE;
      2: return IN_W'($urandom_range(int'(ONE) + 1, int'(TOP_IN)));
      default: return IN_W'($urandom_range(0, int'(ONE)));
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pick_hue();
    int k;
    k = $urandom_range(1, 5);
    case ($urandom_range(0, 11))
      0: return ONE;
      1: return IN_W'($urandom_range(int'(ONE) + 1, int'(TOP_IN)));
      2: return IN_W'((k * int'(ONE)) / 6 + $urandom_range(0, 2) - 1);
      default: return IN_W'($urandom_range(0, int'(ONE) - 1));
    endcase
  endfunction

  task automatic send_pixel(input logic [IN_W-1:0] h, input logic [IN_W-1:0] s,
                            input logic [IN_W-1:0] v);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 2) == 0) gap = idle_len();
    if (gap > 0) begin
      hsv.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hsv.valid      <= 1'b1;
    hsv.hue        <= h;
    hsv.saturation <= s;
    hsv.brightness <= v;
    do @(posedge clk); while (!hsv.ready);
  endtask

  task automatic hold_until_empty();
    hsv.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || steady) begin
      rgb.ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rgb.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      rgb.ready  <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      rgb.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("hsv_to_rgb_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst            <= 1'b1;
    steady         <= 1'b0;
    hsv.valid      <= 1'b0;
    hsv.hue        <= '0;
    hsv.saturation <= '0;
    hsv.brightness <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel('0, ONE, ONE);
    send_pixel(ONE, ONE, ONE);
    send_pixel(ONE - 1, ONE, ONE);
    send_pixel(TOP_IN, TOP_IN, TOP_IN);
    send_pixel(17'd70000, ONE, ONE);
    send_pixel(17'd10922, ONE, ONE);
    send_pixel(17'd10923, ONE, ONE);
    send_pixel(17'd21845, ONE, ONE);
    send_pixel(17'd21846, ONE, ONE);
    send_pixel(17'd32767, ONE, ONE);
    send_pixel(17'd32768, ONE, ONE);
    send_pixel(17'd43690, ONE, ONE);
    send_pixel(17'd43691, ONE, ONE);
    send_pixel(17'd54613, ONE, ONE);
    send_pixel(17'd54614, ONE, ONE);
    send_pixel(17'd20000, '0, ONE);
    send_pixel(17'd20000, ONE, '0);
    send_pixel(17'd30000, ONE + 1, ONE + 1);
    send_pixel(17'd40000, 17'd100000, ONE);
    send_pixel(17'd50000, ONE, 17'd100000);
    send_pixel(17'd60000, 17'd32768, 17'd32768);
    send_pixel(17'd5000, 17'd1, 17'd1);
    send_pixel(17'd32768, ONE - 1, ONE - 1);
    hold_until_empty();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 150 == 100) steady <= 1'b1;
      if (i % 150 == 140) steady <= 1'b0;
      if (i == RANDOM_PIXELS / 2) hold_until_empty();
      send_pixel(pick_hue(), pick_level(), pick_level());
    end
    hsv.valid <= 1'b0;
    steady    <= 1'b0;

    wait (pending == 0);
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("hsv_to_rgb_unit regression: pass");
    end else begin
      $display("hsv_to_rgb_unit regression: fail");
    end
    $finish;
  end

endmodule
